### design/process_slot_round_robin_scheduler_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the task slot scheduler
// Each macro expands to one labeled concurrent assertion.
// ---------------------------------------------------------------------------
`ifndef PROCESS_SLOT_ROUND_ROBIN_SCHEDULER_TOP_MACROS_SVH
`define PROCESS_SLOT_ROUND_ROBIN_SCHEDULER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PSRRS_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed in the same cycle");

// Consequent checked in the cycle after the antecedent.
`define PSRRS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed in the next cycle");

`endif

### design/psrrs_pkg.sv
// ---------------------------------------------------------------------------
// Task slot scheduler package
// Sizes, command and status codes, register indexes and reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package psrrs_pkg;

   localparam int TASK_SLOTS = 16;
   localparam int ID_W       = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CMD_W      = 3;
   localparam int TID_W      = 4;
   localparam int STATUS_W   = 2;
   localparam int ADDR_W     = 32;
   localparam int CSR_IDX_W  = 3;

   typedef logic [CMD_W-1:0]     cmd_type;
   typedef logic [TID_W-1:0]     tid_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [ID_W-1:0]      slot_id_type;

   typedef enum logic [1:0] {
      RS_READY,
      RS_RUNNING,
      RS_BLOCKED
   } run_state_type;

   localparam cmd_type CMD_FORK    = 3'd0;
   localparam cmd_type CMD_EXIT    = 3'd1;
   localparam cmd_type CMD_BLOCK   = 3'd2;
   localparam cmd_type CMD_UNBLOCK = 3'd3;
   localparam cmd_type CMD_YIELD   = 3'd4;

   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_NO_FREE  = 2'd1;
   localparam status_type STATUS_NO_READY = 2'd2;

   localparam csr_idx_type CSR_KERNEL_STACK_BASE  = 3'd0;
   localparam csr_idx_type CSR_TASK_MEMORY_BASE   = 3'd1;
   localparam csr_idx_type CSR_TASK_MEMORY_STRIDE = 3'd2;
   localparam csr_idx_type CSR_PAGE_DIR_BASE      = 3'd3;
   localparam csr_idx_type CSR_PAGE_DIR_STRIDE    = 3'd4;

   localparam addr_type KERNEL_STACK_BASE_RST  = 32'd0;
   localparam addr_type TASK_MEMORY_BASE_RST   = 32'd0;
   localparam addr_type TASK_MEMORY_STRIDE_RST = 32'd4194304;
   localparam addr_type PAGE_DIR_BASE_RST      = 32'd0;
   localparam addr_type PAGE_DIR_STRIDE_RST    = 32'd4096;

endpackage

`default_nettype wire

### design/psrrs_if.sv
// ---------------------------------------------------------------------------
// Task slot scheduler channels
// Command, result and register write channels with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface psrrs_req_if;
   import psrrs_pkg::*;
   logic    valid;
   logic    ready;
   cmd_type command;
   tid_type target_id;
   modport source (output valid, command, target_id, input ready);
   modport sink   (input valid, command, target_id, output ready);
endinterface

interface psrrs_rsp_if;
   import psrrs_pkg::*;
   logic       valid;
   logic       ready;
   status_type status;
   tid_type    task_id;
   tid_type    parent_id;
   addr_type   stack_top;
   addr_type   page_dir_addr;
   modport source (output valid, status, task_id, parent_id, stack_top, page_dir_addr,
                   input ready);
   modport sink   (input valid, status, task_id, parent_id, stack_top, page_dir_addr,
                   output ready);
endinterface

interface psrrs_csr_if;
   import psrrs_pkg::*;
   logic        valid;
   logic        ready;
   csr_idx_type index;
   addr_type    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/process_slot_round_robin_scheduler_top.sv
// ---------------------------------------------------------------------------
// Task slot scheduler: modify, scan (not for unblock, odd codes), multiply A/B, finish.
// One request at a time; scans visit one slot per cycle, one shared multiplier.
// Reset: synchronous; slot 0 running, others free, registers at reset values.
// ---------------------------------------------------------------------------
`default_nettype none

`include "process_slot_round_robin_scheduler_top_macros.svh"

module process_slot_round_robin_scheduler_top (
   input  wire logic clock,
   input  wire logic reset,
   psrrs_req_if.sink   req_bus,
   psrrs_rsp_if.source rsp_bus,
   psrrs_csr_if.sink   csr_bus
);
   import psrrs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MODIFY,
      ST_SCAN,
      ST_MUL_A,
      ST_MUL_B,
      ST_FINISH
   } state_type;

   state_type     state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   tid_type       target_ff, target_in;
   slot_id_type   idx_ff, idx_in;
   slot_id_type   count_ff, count_in;
   slot_id_type   current_ff, current_in;
   status_type    status_ff, status_in;
   logic          clear_ff, clear_in;
   addr_type      prod_ff, prod_in;
   addr_type      stack_ff, stack_in;

   logic [TASK_SLOTS-1:0] used_ff, used_in;
   run_state_type         run_ff [TASK_SLOTS];
   run_state_type         run_in [TASK_SLOTS];
   slot_id_type           parent_ff [TASK_SLOTS];
   slot_id_type           parent_in [TASK_SLOTS];

   addr_type kstack_ff, kstack_in;
   addr_type tmem_base_ff, tmem_base_in;
   addr_type tmem_stride_ff, tmem_stride_in;
   addr_type pdir_base_ff, pdir_base_in;
   addr_type pdir_stride_ff, pdir_stride_in;

   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   tid_type    rsp_task_ff, rsp_task_in;
   tid_type    rsp_parent_ff, rsp_parent_in;
   addr_type   rsp_stack_ff, rsp_stack_in;
   addr_type   rsp_pdir_ff, rsp_pdir_in;

   slot_id_type           idx_next;
   logic                  scan_last;
   logic                  target_oor;
   addr_type              mul_operand;
   addr_type              mul_result;
   logic [TASK_SLOTS-1:0] running_vec;

   assign idx_next   = (idx_ff == ID_W'(TASK_SLOTS - 1)) ? '0 : idx_ff + ID_W'(1);
   assign scan_last  = (count_ff == ID_W'(TASK_SLOTS - 1));
   assign target_oor = (9'(target_ff) >= 9'(TASK_SLOTS));

   // shared multiplier: task stride first, page directory stride second
   assign mul_operand = (state_ff == ST_MUL_A) ? tmem_stride_ff : pdir_stride_ff;
   assign mul_result  = mul_operand * ADDR_W'(idx_ff);

   always_comb begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
         running_vec[i] = used_ff[i] && (run_ff[i] == RS_RUNNING);
      end
   end

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign csr_bus.ready         = 1'b1;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.task_id       = rsp_task_ff;
   assign rsp_bus.parent_id     = rsp_parent_ff;
   assign rsp_bus.stack_top     = rsp_stack_ff;
   assign rsp_bus.page_dir_addr = rsp_pdir_ff;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      target_in      = target_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      current_in     = current_ff;
      status_in      = status_ff;
      clear_in       = clear_ff;
      prod_in        = prod_ff;
      stack_in       = stack_ff;
      used_in        = used_ff;
      run_in         = run_ff;
      parent_in      = parent_ff;
      kstack_in      = kstack_ff;
      tmem_base_in   = tmem_base_ff;
      tmem_stride_in = tmem_stride_ff;
      pdir_base_in   = pdir_base_ff;
      pdir_stride_in = pdir_stride_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_task_in    = rsp_task_ff;
      rsp_parent_in  = rsp_parent_ff;
      rsp_stack_in   = rsp_stack_ff;
      rsp_pdir_in    = rsp_pdir_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_KERNEL_STACK_BASE:  kstack_in      = csr_bus.data;
            CSR_TASK_MEMORY_BASE:   tmem_base_in   = csr_bus.data;
            CSR_TASK_MEMORY_STRIDE: tmem_stride_in = csr_bus.data;
            CSR_PAGE_DIR_BASE:      pdir_base_in   = csr_bus.data;
            CSR_PAGE_DIR_STRIDE:    pdir_stride_in = csr_bus.data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               cmd_in    = req_bus.command;
               target_in = req_bus.target_id;
               idx_in    = (req_bus.command == CMD_UNBLOCK) ? ID_W'(req_bus.target_id)
                                                            : current_ff;
               count_in  = '0;
               status_in = STATUS_OK;
               clear_in  = 1'b0;
               state_in  = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            unique case (cmd_ff)
               CMD_FORK: begin
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end
               CMD_EXIT: begin
                  if (used_ff[idx_ff]) begin
                     used_in[idx_ff] = 1'b0;
                     run_in[idx_ff]  = RS_READY;
                  end
                  idx_in   = idx_next;
                  state_in = ST_SCAN;
               end
               CMD_BLOCK: begin
                  if (used_ff[idx_ff]) begin
                     run_in[idx_ff] = RS_BLOCKED;
                  end
                  idx_in   = idx_next;
                  state_in = ST_SCAN;
               end
               CMD_YIELD: begin
                  if (used_ff[idx_ff] && run_ff[idx_ff] == RS_RUNNING) begin
                     run_in[idx_ff] = RS_READY;
                  end
                  idx_in   = idx_next;
                  state_in = ST_SCAN;
               end
               CMD_UNBLOCK: begin
                  clear_in = target_oor;
                  if (!target_oor && used_ff[idx_ff] && run_ff[idx_ff] == RS_BLOCKED) begin
                     run_in[idx_ff] = RS_READY;
                  end
                  state_in = ST_MUL_A;
               end
               default: state_in = ST_MUL_A;
            endcase
         end
         ST_SCAN: begin
            count_in = count_ff + ID_W'(1);
            if (cmd_ff == CMD_FORK) begin
               if (!used_ff[idx_ff]) begin
                  used_in[idx_ff]   = 1'b1;
                  run_in[idx_ff]    = RS_READY;
                  parent_in[idx_ff] = current_ff;
                  state_in          = ST_MUL_A;
               end else if (scan_last) begin
                  idx_in    = '0;
                  clear_in  = 1'b1;
                  status_in = STATUS_NO_FREE;
                  state_in  = ST_MUL_A;
               end else begin
                  idx_in = idx_next;
               end
            end else begin
               if (used_ff[idx_ff] && run_ff[idx_ff] == RS_READY) begin
                  run_in[idx_ff] = RS_RUNNING;
                  current_in     = idx_ff;
                  state_in       = ST_MUL_A;
               end else if (scan_last) begin
                  // nothing ready: report the current slot as it stands
                  idx_in    = current_ff;
                  status_in = STATUS_NO_READY;
                  state_in  = ST_MUL_A;
               end else begin
                  idx_in = idx_next;
               end
            end
         end
         ST_MUL_A: begin
            prod_in  = mul_result;
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            stack_in = (idx_ff == '0) ? kstack_ff : tmem_base_ff + prod_ff;
            prod_in  = mul_result;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_task_in   = (cmd_ff == CMD_UNBLOCK) ? target_ff : TID_W'(idx_ff);
               rsp_parent_in = clear_ff ? '0 : TID_W'(parent_ff[idx_ff]);
               rsp_stack_in  = clear_ff ? '0 : stack_ff;
               rsp_pdir_in   = clear_ff ? '0 : pdir_base_ff + prod_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         current_ff     <= '0;
         used_ff        <= TASK_SLOTS'(1);
         rsp_valid_ff   <= 1'b0;
         kstack_ff      <= KERNEL_STACK_BASE_RST;
         tmem_base_ff   <= TASK_MEMORY_BASE_RST;
         tmem_stride_ff <= TASK_MEMORY_STRIDE_RST;
         pdir_base_ff   <= PAGE_DIR_BASE_RST;
         pdir_stride_ff <= PAGE_DIR_STRIDE_RST;
         for (int i = 0; i < TASK_SLOTS; i++) begin
            run_ff[i]    <= (i == 0) ? RS_RUNNING : RS_READY;
            parent_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         current_ff     <= current_in;
         used_ff        <= used_in;
         rsp_valid_ff   <= rsp_valid_in;
         kstack_ff      <= kstack_in;
         tmem_base_ff   <= tmem_base_in;
         tmem_stride_ff <= tmem_stride_in;
         pdir_base_ff   <= pdir_base_in;
         pdir_stride_ff <= pdir_stride_in;
         run_ff         <= run_in;
         parent_ff      <= parent_in;
      end
      cmd_ff        <= cmd_in;
      target_ff     <= target_in;
      idx_ff        <= idx_in;
      count_ff      <= count_in;
      status_ff     <= status_in;
      clear_ff      <= clear_in;
      prod_ff       <= prod_in;
      stack_ff      <= stack_in;
      rsp_status_ff <= rsp_status_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_parent_ff <= rsp_parent_in;
      rsp_stack_ff  <= rsp_stack_in;
      rsp_pdir_ff   <= rsp_pdir_in;
   end

   `PSRRS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready)
   `PSRRS_ASSERT_SAME(a_one_running_task, clock, reset, 1'b1, $countones(running_vec) <= 1)
   `PSRRS_ASSERT_SAME(a_no_free_is_empty, clock, reset, rsp_bus.valid && rsp_bus.status == STATUS_NO_FREE, rsp_bus.task_id == '0 && rsp_bus.stack_top == '0 && rsp_bus.page_dir_addr == '0)

endmodule

`default_nettype wire
